// ===== hw/rtl/hnfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hnfp_pkg: shared types and codes of the home network frame parser
// Field kinds, frame forms, status codes and the one-hot parse phases.
// ----------------------------------------------------------------------------
package hnfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned FORM_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TID_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Object identifiers are three bytes long
  localparam logic [BYTE_W-1:0] OBJ_LAST   = 8'd2;
  localparam logic [BYTE_W-1:0] OFFSET_MAX = 8'd254;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] HDR1_RST    = 8'd16;
  localparam logic [BYTE_W-1:0] DEF_FORM_RST = 8'd129;
  localparam logic [BYTE_W-1:0] ARB_FORM_RST = 8'd130;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR1     = 2'd0,
    CFG_DEF_FORM = 2'd1,
    CFG_ARB_FORM = 2'd2
  } cfg_idx_t;

  // Field kind codes
  typedef enum logic [KIND_W-1:0] {
    KIND_HDR1    = 4'd0,
    KIND_HDR2    = 4'd1,
    KIND_TID     = 4'd2,
    KIND_SRC     = 4'd3,
    KIND_DST     = 4'd4,
    KIND_ESV     = 4'd5,
    KIND_OPC     = 4'd6,
    KIND_EPC     = 4'd7,
    KIND_PDC     = 4'd8,
    KIND_EDT     = 4'd9,
    KIND_PAY     = 4'd10,
    KIND_IGN     = 4'd11,
    KIND_TRAIL   = 4'd12
  } kind_t;

  // Frame form codes
  typedef enum logic [FORM_W-1:0] {
    FORM_NONE      = 2'd0,
    FORM_DEFINED   = 2'd1,
    FORM_ARBITRARY = 2'd2,
    FORM_UNKNOWN   = 2'd3
  } form_t;

  // Frame status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_HEADER = 2'd1,
    ST_TRUNC  = 2'd2,
    ST_TRAIL  = 2'd3
  } status_t;

  // Parse phases, one-hot
  typedef enum logic [12:0] {
    PH_HDR1 = 13'b0_0000_0000_0001,
    PH_HDR2 = 13'b0_0000_0000_0010,
    PH_TID  = 13'b0_0000_0000_0100,
    PH_SRC  = 13'b0_0000_0000_1000,
    PH_DST  = 13'b0_0000_0001_0000,
    PH_ESV  = 13'b0_0000_0010_0000,
    PH_OPC  = 13'b0_0000_0100_0000,
    PH_EPC  = 13'b0_0000_1000_0000,
    PH_PDC  = 13'b0_0001_0000_0000,
    PH_EDT  = 13'b0_0010_0000_0000,
    PH_PAY  = 13'b0_0100_0000_0000,
    PH_IGN  = 13'b0_1000_0000_0000,
    PH_DONE = 13'b1_0000_0000_0000
  } phase_t;

endpackage

// ===== hw/rtl/hnfp_in_if.sv =====
// ----------------------------------------------------------------------------
// hnfp_in_if: frame byte channel
// One beat carries one raw frame byte and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface hnfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

// ===== hw/rtl/hnfp_out_if.sv =====
// ----------------------------------------------------------------------------
// hnfp_out_if: tagged byte channel
// One beat carries the field tag of one byte and, at frame end, the status.
// ----------------------------------------------------------------------------
interface hnfp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [7:0]  field_offset;
  logic [7:0]  property_number;
  logic [1:0]  frame_form;
  logic        frame_done;
  logic [1:0]  frame_status;
  logic [15:0] transaction_id;

  modport source (output valid, output field_kind, output field_offset,
                  output property_number, output frame_form, output frame_done,
                  output frame_status, output transaction_id, input ready);
  modport sink   (input valid, input field_kind, input field_offset,
                  input property_number, input frame_form, input frame_done,
                  input frame_status, input transaction_id, output ready);
endinterface

// ===== hw/rtl/home_net_frame_parser.sv =====
// ----------------------------------------------------------------------------
// home_net_frame_parser: byte-wise frame field tagger
// Tags each byte of a home network frame with its field and reports status
// and transaction id on the last byte.
//
//   channel  dir  beat contents
//   in_ch    in   frame_byte, end_of_frame
//   out_ch   out  field_kind, field_offset, property_number, frame_form,
//                 frame_done, frame_status, transaction_id
//   cfg_*    in   cfg_we, cfg_index, cfg_wdata (write only)
//
// One byte is accepted per cycle while in_ch.ready is high; its result
// appears in the output register in the next cycle. The parse state is
// updated in the same cycle a byte is taken.
// Reset (synchronous rst_n) returns the parser to the first header byte and
// loads the configuration defaults.
// in_ch.ready drops only while the output register is full and not taken.
// ----------------------------------------------------------------------------
module home_net_frame_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  hnfp_in_if.sink                         in_ch,
  hnfp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [hnfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hnfp_pkg::BYTE_W-1:0]     cfg_wdata
);
  import hnfp_pkg::*;

  // Configuration registers
  logic [BYTE_W-1:0] hdr1_val_r;
  logic [BYTE_W-1:0] def_code_r;
  logic [BYTE_W-1:0] arb_code_r;

  // Parse state
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] props_left_r, props_left_nxt;
  logic [BYTE_W-1:0] data_left_r, data_left_nxt;
  logic [BYTE_W-1:0] prop_idx_r, prop_idx_nxt;
  form_t             form_r, form_nxt;
  status_t           err_r, err_nxt;
  logic [TID_W-1:0]  tid_r, tid_nxt;

  // Output register
  logic              out_valid_r;
  kind_t             kind_r, kind_nxt;
  logic [BYTE_W-1:0] off_r, off_nxt;
  logic [BYTE_W-1:0] prop_r, prop_nxt;
  form_t             oform_r;
  logic              done_r;
  status_t           status_r, status_nxt;
  logic [TID_W-1:0]  otid_r, otid_nxt;

  logic              in_fire;
  logic              last;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] cnt_sat;
  logic [BYTE_W-1:0] data_dec;
  logic [BYTE_W-1:0] props_dec;
  logic              complete;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign last     = in_ch.end_of_frame;
  assign b        = in_ch.frame_byte;
  assign in_ch.ready = ~out_valid_r | out_ch.ready;

  assign cnt_sat   = (cnt_r < OFFSET_MAX) ? cnt_r + 8'd1 : cnt_r;
  assign data_dec  = data_left_r - 8'd1;
  assign props_dec = props_left_r - 8'd1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr1_val_r <= HDR1_RST;
      def_code_r <= DEF_FORM_RST;
      arb_code_r <= ARB_FORM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HDR1:     hdr1_val_r <= cfg_wdata;
        CFG_DEF_FORM: def_code_r <= cfg_wdata;
        CFG_ARB_FORM: arb_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Tag the byte and advance the parse state
  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    props_left_nxt = props_left_r;
    data_left_nxt  = data_left_r;
    prop_idx_nxt   = prop_idx_r;
    form_nxt       = form_r;
    err_nxt        = err_r;
    tid_nxt        = tid_r;
    kind_nxt       = KIND_IGN;
    off_nxt        = '0;
    prop_nxt       = '0;

    unique case (phase_r)
      PH_HDR1: begin
        kind_nxt = KIND_HDR1;
        cnt_nxt  = '0;
        if (b != hdr1_val_r) begin
          err_nxt   = ST_HEADER;
          phase_nxt = PH_IGN;
        end else begin
          phase_nxt = PH_HDR2;
        end
      end
      PH_HDR2: begin
        kind_nxt  = KIND_HDR2;
        cnt_nxt   = '0;
        phase_nxt = PH_TID;
        if (b == def_code_r)      form_nxt = FORM_DEFINED;
        else if (b == arb_code_r) form_nxt = FORM_ARBITRARY;
        else                      form_nxt = FORM_UNKNOWN;
      end
      PH_TID: begin
        kind_nxt = KIND_TID;
        off_nxt  = cnt_r;
        if (cnt_r == '0) begin
          tid_nxt = {b, tid_r[7:0]};
          cnt_nxt = 8'd1;
        end else begin
          tid_nxt = {tid_r[15:8], b};
          cnt_nxt = '0;
          if (form_r == FORM_DEFINED)        phase_nxt = PH_SRC;
          else if (form_r == FORM_ARBITRARY) phase_nxt = PH_PAY;
          else                               phase_nxt = PH_IGN;
        end
      end
      PH_SRC, PH_DST: begin
        kind_nxt = (phase_r == PH_SRC) ? KIND_SRC : KIND_DST;
        off_nxt  = cnt_r;
        if (cnt_r >= OBJ_LAST) begin
          cnt_nxt   = '0;
          phase_nxt = (phase_r == PH_SRC) ? PH_DST : PH_ESV;
        end else begin
          cnt_nxt = cnt_r + 8'd1;
        end
      end
      PH_ESV: begin
        kind_nxt  = KIND_ESV;
        phase_nxt = PH_OPC;
      end
      PH_OPC: begin
        kind_nxt       = KIND_OPC;
        props_left_nxt = b;
        prop_idx_nxt   = '0;
        cnt_nxt        = '0;
        phase_nxt      = (b != '0) ? PH_EPC : PH_DONE;
      end
      PH_EPC: begin
        kind_nxt  = KIND_EPC;
        prop_nxt  = prop_idx_r;
        phase_nxt = PH_PDC;
      end
      PH_PDC: begin
        kind_nxt      = KIND_PDC;
        prop_nxt      = prop_idx_r;
        data_left_nxt = b;
        cnt_nxt       = '0;
        if (b != '0) begin
          phase_nxt = PH_EDT;
        end else begin
          // close the empty property
          props_left_nxt = props_dec;
          if (props_dec == '0) begin
            phase_nxt = PH_DONE;
          end else begin
            prop_idx_nxt = prop_idx_r + 8'd1;
            phase_nxt    = PH_EPC;
          end
        end
      end
      PH_EDT: begin
        kind_nxt      = KIND_EDT;
        prop_nxt      = prop_idx_r;
        off_nxt       = cnt_r;
        cnt_nxt       = cnt_r + 8'd1;
        data_left_nxt = data_dec;
        if (data_dec == '0) begin
          // last data byte closes the property
          cnt_nxt        = '0;
          props_left_nxt = props_dec;
          if (props_dec == '0) begin
            phase_nxt = PH_DONE;
          end else begin
            prop_idx_nxt = prop_idx_r + 8'd1;
            phase_nxt    = PH_EPC;
          end
        end
      end
      PH_PAY: begin
        kind_nxt = KIND_PAY;
        off_nxt  = cnt_r;
        cnt_nxt  = cnt_sat;
      end
      PH_DONE: begin
        kind_nxt = KIND_TRAIL;
        off_nxt  = cnt_r;
        cnt_nxt  = cnt_sat;
        err_nxt  = ST_TRAIL;
      end
      default: begin
        kind_nxt = KIND_IGN;
        off_nxt  = cnt_r;
        cnt_nxt  = cnt_sat;
      end
    endcase

    complete = (phase_nxt == PH_DONE) || (phase_nxt == PH_PAY) ||
               ((phase_nxt == PH_IGN) && (form_nxt == FORM_UNKNOWN));

    // Report status and id on the last byte only
    status_nxt = ST_OK;
    otid_nxt   = '0;
    if (last) begin
      otid_nxt = tid_nxt;
      priority if (err_nxt == ST_HEADER) status_nxt = ST_HEADER;
      else if (err_nxt == ST_TRAIL)      status_nxt = ST_TRAIL;
      else if (complete)                 status_nxt = ST_OK;
      else                               status_nxt = ST_TRUNC;
    end
  end

  // Hold parse state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR1;
      cnt_r        <= '0;
      props_left_r <= '0;
      data_left_r  <= '0;
      prop_idx_r   <= '0;
      form_r       <= FORM_NONE;
      err_r        <= ST_OK;
      tid_r        <= '0;
    end else if (in_fire) begin
      if (last) begin
        phase_r      <= PH_HDR1;
        cnt_r        <= '0;
        props_left_r <= '0;
        data_left_r  <= '0;
        prop_idx_r   <= '0;
        form_r       <= FORM_NONE;
        err_r        <= ST_OK;
        tid_r        <= '0;
      end else begin
        phase_r      <= phase_nxt;
        cnt_r        <= cnt_nxt;
        props_left_r <= props_left_nxt;
        data_left_r  <= data_left_nxt;
        prop_idx_r   <= prop_idx_nxt;
        form_r       <= form_nxt;
        err_r        <= err_nxt;
        tid_r        <= tid_nxt;
      end
    end
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= kind_nxt;
      off_r    <= off_nxt;
      prop_r   <= prop_nxt;
      oform_r  <= form_nxt;
      done_r   <= last;
      status_r <= status_nxt;
      otid_r   <= otid_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.field_kind      = kind_r;
  assign out_ch.field_offset    = off_r;
  assign out_ch.property_number = prop_r;
  assign out_ch.frame_form      = oform_r;
  assign out_ch.frame_done      = done_r;
  assign out_ch.frame_status    = status_r;
  assign out_ch.transaction_id  = otid_r;

  // A frame end always restarts at the first header byte
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last) |=> (phase_r == PH_HDR1 && form_r == FORM_NONE && err_r == ST_OK))
    else $error("parser did not restart after frame end");

  // Status and id stay zero on bytes that do not end a frame
  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !done_r) |-> (status_r == ST_OK && otid_r == '0))
    else $error("status or id set on a mid-frame byte");

  // Property number is only used by property fields
  a_prop_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && prop_r != '0) |->
      (kind_r == KIND_EPC || kind_r == KIND_PDC || kind_r == KIND_EDT))
    else $error("property number on a non-property field");

  // A bad first header never reports a known form
  a_bad_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r && status_r == ST_HEADER) |-> (oform_r == FORM_NONE))
    else $error("form reported for a frame with a bad header");

endmodule

// ===== tb/sv/hnfp_tag_checker.sv =====
// ----------------------------------------------------------------------------
// hnfp_tag_checker: field tag scoreboard for the home network frame parser
// Watches both channels and the register write port. Keeps its own parse
// state, predicts the tag of every accepted frame byte, and compares each
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hnfp_tag_checker import hnfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  hnfp_in_if                in_ch,
  hnfp_out_if               out_ch,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  offset;
    logic [7:0]  prop;
    form_t       form;
    logic        done;
    status_t     status;
    logic [15:0] tid;
  } byte_tag_t;

  // Register copies
  logic [7:0] hdr1_value;
  logic [7:0] def_code;
  logic [7:0] arb_code;

  // Parse state of the frame in progress
  phase_t      phase;
  logic [7:0]  offs;
  logic [7:0]  props_left;
  logic [7:0]  data_left;
  logic [7:0]  prop_idx;
  form_t       form;
  status_t     err;
  logic [15:0] tid_reg;

  byte_tag_t   expected_tags[$];
  int unsigned out_beats;

  function automatic void clear_frame();
    phase      = PH_HDR1;
    offs       = '0;
    props_left = '0;
    data_left  = '0;
    prop_idx   = '0;
    form       = FORM_NONE;
    err        = ST_OK;
    tid_reg    = '0;
  endfunction

  // Advance to the next property, or finish the frame after the last one
  function automatic void close_property();
    props_left = props_left - 8'd1;
    if (props_left == 8'd0) begin
      phase = PH_DONE;
      offs  = '0;
    end else begin
      prop_idx = prop_idx + 8'd1;
      phase    = PH_EPC;
    end
  endfunction

  // Return the offset and step it, holding at the ceiling
  function automatic logic [7:0] bump_offset();
    logic [7:0] o;
    o = offs;
    if (offs < OFFSET_MAX) offs = offs + 8'd1;
    return o;
  endfunction

  function automatic byte_tag_t tag_byte(input logic [7:0] b, input logic last);
    byte_tag_t t;
    logic      complete;
    t = '{kind: KIND_IGN, offset: 8'd0, prop: 8'd0, form: FORM_NONE, done: last,
          status: ST_OK, tid: 16'd0};
    case (phase)
      PH_HDR1: begin
        t.kind = KIND_HDR1;
        if (b != hdr1_value) begin
          err   = ST_HEADER;
          phase = PH_IGN;
        end else begin
          phase = PH_HDR2;
        end
        offs = '0;
      end
      PH_HDR2: begin
        t.kind = KIND_HDR2;
        // defined form takes priority when both codes match
        if (b == def_code) form = FORM_DEFINED;
        else if (b == arb_code) form = FORM_ARBITRARY;
        else form = FORM_UNKNOWN;
        phase = PH_TID;
        offs  = '0;
      end
      PH_TID: begin
        t.kind   = KIND_TID;
        t.offset = offs;
        if (offs == 8'd0) begin
          tid_reg[15:8] = b;
          offs          = 8'd1;
        end else begin
          tid_reg[7:0] = b;
          offs         = '0;
          case (form)
            FORM_DEFINED:   phase = PH_SRC;
            FORM_ARBITRARY: phase = PH_PAY;
            default:        phase = PH_IGN;
          endcase
        end
      end
      PH_SRC, PH_DST: begin
        if (phase == PH_SRC) t.kind = KIND_SRC;
        else t.kind = KIND_DST;
        t.offset = offs;
        if (offs >= OBJ_LAST) begin
          offs = '0;
          if (phase == PH_SRC) phase = PH_DST;
          else phase = PH_ESV;
        end else begin
          offs = offs + 8'd1;
        end
      end
      PH_ESV: begin
        t.kind = KIND_ESV;
        phase  = PH_OPC;
      end
      PH_OPC: begin
        t.kind     = KIND_OPC;
        props_left = b;
        prop_idx   = '0;
        offs       = '0;
        if (b != 8'd0) phase = PH_EPC;
        else phase = PH_DONE;
      end
      PH_EPC: begin
        t.kind = KIND_EPC;
        t.prop = prop_idx;
        phase  = PH_PDC;
      end
      PH_PDC: begin
        t.kind    = KIND_PDC;
        t.prop    = prop_idx;
        data_left = b;
        offs      = '0;
        if (b != 8'd0) phase = PH_EDT;
        else close_property();
      end
      PH_EDT: begin
        t.kind    = KIND_EDT;
        t.prop    = prop_idx;
        t.offset  = offs;
        offs      = offs + 8'd1;
        data_left = data_left - 8'd1;
        if (data_left == 8'd0) begin
          offs = '0;
          close_property();
        end
      end
      PH_PAY: begin
        t.kind   = KIND_PAY;
        t.offset = bump_offset();
      end
      PH_DONE: begin
        t.kind   = KIND_TRAIL;
        t.offset = bump_offset();
        err      = ST_TRAIL;
      end
      default: begin
        t.kind   = KIND_IGN;
        t.offset = bump_offset();
      end
    endcase

    complete = (phase == PH_DONE) || (phase == PH_PAY) ||
               (phase == PH_IGN && form == FORM_UNKNOWN);
    t.form = form;

    // Close the frame: status by priority, then start over
    if (last) begin
      if (err == ST_HEADER) t.status = ST_HEADER;
      else if (err == ST_TRAIL) t.status = ST_TRAIL;
      else if (complete) t.status = ST_OK;
      else t.status = ST_TRUNC;
      t.tid = tid_reg;
      clear_frame();
    end
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] tag mismatch at beat %0d: %s", $time, out_beats, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Track registers, predict on input beats, compare on output beats
  always @(posedge clk) begin : watch
    byte_tag_t want;
    if (!rst_n) begin
      hdr1_value = HDR1_RST;
      def_code   = DEF_FORM_RST;
      arb_code   = ARB_FORM_RST;
      clear_frame();
      expected_tags.delete();
      out_beats = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HDR1:     hdr1_value = cfg_wdata;
          CFG_DEF_FORM: def_code   = cfg_wdata;
          CFG_ARB_FORM: arb_code   = cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tags.size() == 0) begin
          report_mismatch("result beat with no byte outstanding");
        end else begin
          want = expected_tags.pop_front();
          check_field("field_kind", out_ch.field_kind, want.kind);
          check_field("field_offset", out_ch.field_offset, want.offset);
          check_field("property_number", out_ch.property_number, want.prop);
          check_field("frame_form", out_ch.frame_form, want.form);
          check_field("frame_done", out_ch.frame_done, want.done);
          check_field("frame_status", out_ch.frame_status, want.status);
          check_field("transaction_id", out_ch.transaction_id, want.tid);
        end
        out_beats++;
      end
      if (in_ch.valid && in_ch.ready)
        expected_tags.push_back(tag_byte(in_ch.frame_byte, in_ch.end_of_frame));
    end
    pending = expected_tags.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the home network frame parser
// Drives directed frames, then random frames under several register
// settings with random idling on both channels and one long output stall.
// The tag checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import hnfp_pkg::*;

  typedef logic [7:0] frame_t[$];

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned PHASE_BYTES  = 50;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [7:0]  cfg_wdata;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          squeeze_req = 1'b0;

  // Register values that the frame builders follow
  logic [7:0] hdr1_val = HDR1_RST;
  logic [7:0] def_code = DEF_FORM_RST;
  logic [7:0] arb_code = ARB_FORM_RST;

  hnfp_in_if  in_ch();
  hnfp_out_if out_ch();

  always #1 clk = ~clk;

  home_net_frame_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  hnfp_tag_checker tag_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Mostly short gaps, now and then a long one, none while calm
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic frame_t defined_frame();
    frame_t      f;
    int unsigned n_props;
    int unsigned len;
    f = {hdr1_val, def_code, 8'($urandom), 8'($urandom)};
    // source object, destination object, service code
    repeat (7) f.push_back(8'($urandom));
    n_props = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    f.push_back(8'(n_props));
    repeat (n_props) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
      f.push_back(8'($urandom));
      f.push_back(8'(len));
      repeat (len) f.push_back(8'($urandom));
    end
    return f;
  endfunction

  function automatic frame_t arbitrary_frame(input int unsigned n);
    frame_t f;
    f = {hdr1_val, arb_code, 8'($urandom), 8'($urandom)};
    repeat (n) f.push_back(8'($urandom));
    return f;
  endfunction

  function automatic frame_t unknown_frame(input int unsigned n);
    frame_t     f;
    logic [7:0] b;
    do b = 8'($urandom); while (b == def_code || b == arb_code);
    f = {hdr1_val, b, 8'($urandom), 8'($urandom)};
    repeat (n) f.push_back(8'($urandom));
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned pick;
    int unsigned cut;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      f = defined_frame();
    end else if (pick < 58) begin
      f = arbitrary_frame($urandom_range(0, 8));
    end else if (pick < 68) begin
      f = unknown_frame($urandom_range(0, 4));
    end else if (pick < 80) begin
      // cut a frame short of its structure
      case ($urandom_range(0, 2))
        0:       f = defined_frame();
        1:       f = arbitrary_frame(0);
        default: f = unknown_frame(0);
      endcase
      cut = $urandom_range(1, f.size() - 1);
      while (f.size() > cut) void'(f.pop_back());
    end else if (pick < 88) begin
      f = defined_frame();
      repeat ($urandom_range(1, 3)) f.push_back(8'($urandom));
    end else if (pick < 94) begin
      do b = 8'($urandom); while (b == hdr1_val);
      f = {b};
      repeat ($urandom_range(0, 3)) f.push_back(8'($urandom));
    end else begin
      // raw noise
      repeat ($urandom_range(1, 6)) f.push_back(8'($urandom));
    end
    return f;
  endfunction

  // Offer one beat after a random gap and hold it until taken
  task automatic send_beat(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.frame_byte   <= b;
    in_ch.end_of_frame <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_frame(input frame_t f);
    foreach (f[i]) send_beat(f[i], i == f.size() - 1);
  endtask

  // Drop valid and wait until every byte has come back tagged
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: open and busy stretches, plus one long hold-off on request
  initial begin : receiver
    int unsigned busy_left;
    int unsigned open_left;
    bit          squeezed;
    out_ch.ready = 1'b0;
    busy_left    = 0;
    open_left    = 0;
    squeezed     = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        busy_left = HOLD_CYCLES;
        open_left = 0;
      end
      if (busy_left == 0 && open_left == 0) begin
        open_left = $urandom_range(1, 24);
        busy_left = idle_len();
      end
      if (busy_left != 0) begin
        out_ch.ready <= 1'b0;
        busy_left--;
      end else begin
        out_ch.ready <= 1'b1;
        open_left--;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    frame_t      f;
    int unsigned sent;
    logic [7:0]  r;
    in_ch.valid        = 1'b0;
    in_ch.frame_byte   = '0;
    in_ch.end_of_frame = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_HDR1;
    cfg_wdata          = '0;
    rst_n              = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Bad first header, then an ignored byte
    f = {8'hFF, 8'h00};
    send_frame(f);
    // Frame that stops after the first header byte
    f = {HDR1_RST};
    send_frame(f);
    // Empty arbitrary payload
    f = {HDR1_RST, ARB_FORM_RST, 8'hFF, 8'h00};
    send_frame(f);
    // Unknown form, complete once the id is in
    f = {HDR1_RST, 8'h55, 8'h12, 8'h34};
    send_frame(f);
    // Defined form: empty property, one-byte property, one trailing byte
    f = {HDR1_RST, DEF_FORM_RST, 8'h01, 8'h02, 8'h05, 8'hFF, 8'h01, 8'h0E, 8'hF0, 8'h01,
         8'h62, 8'h02, 8'h80, 8'h00, 8'h81, 8'h01, 8'h5A, 8'h3C};
    send_frame(f);

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        wait_idle();
        case (p)
          1: begin
            hdr1_val = 8'h00; def_code = 8'hFF; arb_code = 8'h00;
          end
          2: begin
            hdr1_val = 8'hFF; def_code = 8'h00; arb_code = 8'hFF;
          end
          3: begin
            // both form codes equal
            r = 8'($urandom);
            hdr1_val = 8'($urandom); def_code = r; arb_code = r;
          end
          4: begin
            hdr1_val = 8'($urandom); def_code = 8'($urandom); arb_code = 8'($urandom);
          end
          default: begin
            hdr1_val = HDR1_RST; def_code = DEF_FORM_RST; arb_code = ARB_FORM_RST;
          end
        endcase
        write_reg(CFG_HDR1, hdr1_val);
        write_reg(CFG_DEF_FORM, def_code);
        write_reg(CFG_ARB_FORM, arb_code);
      end
      calm = (p == 2);
      if (p == 1) squeeze_req = 1'b1;

      sent = 0;
      while (sent < PHASE_BYTES) begin
        f = random_frame();
        send_frame(f);
        sent += f.size();
      end

      // A long payload drives the offset into saturation
      if (p == 1) begin
        f = arbitrary_frame(260);
        send_frame(f);
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
